// ===== sv/wavhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_EOF     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Result status codes.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_RIFF      = 4'd1;
    localparam logic [3:0] ST_WAVE      = 4'd2;
    localparam logic [3:0] ST_FMT_TAG   = 4'd3;
    localparam logic [3:0] ST_FMT_SHORT = 4'd4;
    localparam logic [3:0] ST_NOT_PCM   = 4'd5;
    localparam logic [3:0] ST_BITS      = 4'd6;
    localparam logic [3:0] ST_CHANNELS  = 4'd7;
    localparam logic [3:0] ST_ALIGN     = 4'd8;
    localparam logic [3:0] ST_RATE      = 4'd9;
    localparam logic [3:0] ST_TRUNCATED = 4'd10;

    // Chunk tags as little-endian words.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM     = 16'd1;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_FMT,
        PH_FSIZE,
        PH_CODE,
        PH_CHAN,
        PH_RATE,
        PH_BRATE,
        PH_ALIGN,
        PH_BITS,
        PH_SKIP,
        PH_CTAG,
        PH_CSIZE,
        PH_DONE
    } t_phase;

    // Outcome of the fmt field checks, evaluated on the last byte of bits per sample.
    typedef struct packed {
        logic bits_bad;
        logic chan_bad;
        logic align_bad;
        logic rate_bad;
    } t_fmt_chk;

    // Number of bytes in the field gathered during a phase.
    function automatic logic [2:0] field_len(input t_phase ph);
        logic [2:0] len;
        unique case (ph)
            PH_CODE, PH_CHAN, PH_ALIGN, PH_BITS: len = 3'd2;
            PH_SKIP, PH_DONE:                    len = 3'd1;
            default:                             len = 3'd4;
        endcase
        return len;
    endfunction

    // Bytes per sample: bits over eight, except that 24-bit samples take four bytes.
    function automatic logic [2:0] bytes_for(input logic [5:0] bits);
        return (bits == 6'd24) ? 3'd4 : bits[5:3];
    endfunction

endpackage

`default_nettype wire

// ===== sv/wav_header_parser_core.sv =====
// A beat goes from the input register to the parse step, and its result,
// if any, is registered and offered on the output until it is taken.
// Throughput: one input beat per cycle, set by the input register and the
// single-pass parse step, while the result register is free or drained;
// the rate-times-channels product is registered ahead. Reset: synchronous,
// active low; returns the parser to the RIFF tag and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser_core
    import wavhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [15:0]      o_channels,
    output logic [31:0]      o_sample_rate,
    output logic [5:0]       o_bits_per_sample,
    output logic [2:0]       o_bytes_per_sample,
    output logic             o_signed_samples,
    output logic [31:0]      o_data_size
);

    logic       w_valid;
    logic       w_take;
    logic [1:0] w_kind;
    logic [7:0] w_byte;

    // The input register decouples the upstream beat from the parse step.
    // It refills in the same cycle its beat is consumed.
    wavhp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .o_valid      (w_valid),
        .i_take       (w_take),
        .o_kind       (w_kind),
        .o_byte_value (w_byte)
    );

    // The parser consumes one beat per cycle whenever the result register is
    // free or is being drained. Until a result, byte beats update the phase,
    // the field accumulator or the skip counter; a finished header or an error
    // loads the result register, which holds it until downstream takes it.
    wavhp_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_valid),
        .o_take             (w_take),
        .i_kind             (w_kind),
        .i_byte_value       (w_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_channels         (o_channels),
        .o_sample_rate      (o_sample_rate),
        .o_bits_per_sample  (o_bits_per_sample),
        .o_bytes_per_sample (o_bytes_per_sample),
        .o_signed_samples   (o_signed_samples),
        .o_data_size        (o_data_size)
    );

endmodule

`default_nettype wire

// ===== sv/wavhp_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_in_reg
    import wavhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_byte_value,
    output logic            o_valid,
    input  wire logic       i_take,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_byte_value
);

    logic       r_valid;
    logic       n_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic       c_load;

    // The register can load when it is empty or its beat leaves this cycle.
    assign o_in_ready = i_rst_n && (!r_valid || i_take);
    assign c_load     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (c_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_kind <= i_kind;
            r_byte <= i_byte_value;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_byte_value = r_byte;

endmodule

`default_nettype wire

// ===== sv/wavhp_fmt_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_fmt_check
    import wavhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [15:0] i_channels,
    input  wire logic [31:0] i_rate,
    input  wire logic [31:0] i_byte_rate,
    input  wire logic [15:0] i_align,
    input  wire logic [15:0] i_bits,
    output t_fmt_chk         o_chk
);

    // Rate times channels, refreshed every cycle. Both factors settle at
    // least eight bytes before bits per sample completes.
    logic [47:0] r_rate_chan;
    logic [1:0]  c_shift;
    logic [17:0] c_align_exp;
    logic [49:0] c_brate_exp;

    always_ff @(posedge i_clk) begin
        r_rate_chan <= i_rate * i_channels;
    end

    // Multiplying by one, two or four bytes is a shift.
    always_comb begin
        unique case (i_bits[5:3])
            3'd1:    c_shift = 2'd0;
            3'd2:    c_shift = 2'd1;
            default: c_shift = 2'd2;
        endcase
    end

    assign c_align_exp = {2'b00, i_channels} << c_shift;
    assign c_brate_exp = {2'b00, r_rate_chan} << c_shift;

    always_comb begin
        o_chk.bits_bad  = (i_bits < 16'd8) || (i_bits > 16'd32) || (i_bits[2:0] != 3'd0);
        o_chk.chan_bad  = (i_channels == 16'd0);
        o_chk.align_bad = ({2'b00, i_align} != c_align_exp);
        o_chk.rate_bad  = ({18'd0, i_byte_rate} != c_brate_exp);
    end

endmodule

`default_nettype wire

// ===== sv/wavhp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_parser
    import wavhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_take,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [15:0]      o_channels,
    output logic [31:0]      o_sample_rate,
    output logic [5:0]       o_bits_per_sample,
    output logic [2:0]       o_bytes_per_sample,
    output logic             o_signed_samples,
    output logic [31:0]      o_data_size
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic [31:0] r_shift;
    logic [31:0] n_shift;
    logic [32:0] r_skip;
    logic [32:0] n_skip;
    logic [31:0] r_fmt_len;
    logic [15:0] r_chan;
    logic [31:0] r_rate;
    logic [31:0] r_brate;
    logic [15:0] r_align;
    logic [5:0]  r_bits;
    logic        r_is_data;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [3:0]  r_status;
    logic [15:0] r_o_chan;
    logic [31:0] r_o_rate;
    logic [5:0]  r_o_bits;
    logic [2:0]  r_o_bps;
    logic        r_o_signed;
    logic [31:0] r_o_size;

    logic        c_restart;
    logic        c_eof;
    logic        c_byte;
    logic        c_field;
    logic [2:0]  c_cnt_nx;
    logic [31:0] c_v;
    logic        c_done;
    logic [32:0] c_fmt_skip;
    logic [32:0] c_chunk_skip;
    t_fmt_chk    c_chk;
    logic        c_res;
    logic        c_res_ok;
    logic [3:0]  c_res_status;

    assign o_take = i_valid && (!r_out_valid || i_out_ready);

    assign c_restart = o_take && (i_kind == KIND_RESTART);
    assign c_eof     = o_take && (i_kind == KIND_EOF) && (r_phase != PH_DONE);
    assign c_byte    = o_take && (i_kind == KIND_BYTE) && (r_phase != PH_DONE);
    assign c_field   = c_byte && (r_phase != PH_SKIP);

    assign c_cnt_nx = {1'b0, r_cnt} + 3'd1;
    assign c_v      = r_shift | ({24'd0, i_byte_value} << {r_cnt, 3'b000});
    assign c_done   = c_cnt_nx >= field_len(r_phase);

    assign c_fmt_skip   = (({1'b0, r_fmt_len} + 33'd1) & ~33'd1) - {1'b0, FMT_MIN_LEN};
    assign c_chunk_skip = ({1'b0, c_v} + 33'd1) & ~33'd1;

    wavhp_fmt_check u_fmt_check (
        .i_clk       (i_clk),
        .i_channels  (r_chan),
        .i_rate      (r_rate),
        .i_byte_rate (r_brate),
        .i_align     (r_align),
        .i_bits      (c_v[15:0]),
        .o_chk       (c_chk)
    );

    // Result decision for the current beat.
    always_comb begin
        c_res        = 1'b0;
        c_res_ok     = 1'b0;
        c_res_status = ST_OK;
        if (c_eof) begin
            c_res        = 1'b1;
            c_res_status = ST_TRUNCATED;
        end else if (c_field && c_done) begin
            unique case (r_phase)
                PH_RIFF: begin
                    c_res        = (c_v != TAG_RIFF);
                    c_res_status = ST_RIFF;
                end
                PH_WAVE: begin
                    c_res        = (c_v != TAG_WAVE);
                    c_res_status = ST_WAVE;
                end
                PH_FMT: begin
                    c_res        = (c_v != TAG_FMT);
                    c_res_status = ST_FMT_TAG;
                end
                PH_FSIZE: begin
                    c_res        = (c_v < FMT_MIN_LEN);
                    c_res_status = ST_FMT_SHORT;
                end
                PH_CODE: begin
                    c_res        = (c_v[15:0] != FMT_PCM);
                    c_res_status = ST_NOT_PCM;
                end
                PH_BITS: begin
                    c_res = c_chk.bits_bad || c_chk.chan_bad
                         || c_chk.align_bad || c_chk.rate_bad;
                    priority if (c_chk.bits_bad) begin
                        c_res_status = ST_BITS;
                    end else if (c_chk.chan_bad) begin
                        c_res_status = ST_CHANNELS;
                    end else if (c_chk.align_bad) begin
                        c_res_status = ST_ALIGN;
                    end else begin
                        c_res_status = ST_RATE;
                    end
                end
                PH_CSIZE: begin
                    c_res    = r_is_data;
                    c_res_ok = r_is_data;
                end
                default: begin
                    c_res = 1'b0;
                end
            endcase
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (c_restart) begin
            n_phase = PH_RIFF;
        end else if (c_eof || c_res) begin
            n_phase = PH_DONE;
        end else if (c_byte && (r_phase == PH_SKIP)) begin
            if (r_skip == 33'd1) begin
                n_phase = PH_CTAG;
            end
        end else if (c_field && c_done) begin
            unique case (r_phase)
                PH_RIFF:  n_phase = PH_RSIZE;
                PH_RSIZE: n_phase = PH_WAVE;
                PH_WAVE:  n_phase = PH_FMT;
                PH_FMT:   n_phase = PH_FSIZE;
                PH_FSIZE: n_phase = PH_CODE;
                PH_CODE:  n_phase = PH_CHAN;
                PH_CHAN:  n_phase = PH_RATE;
                PH_RATE:  n_phase = PH_BRATE;
                PH_BRATE: n_phase = PH_ALIGN;
                PH_ALIGN: n_phase = PH_BITS;
                PH_BITS:  n_phase = (c_fmt_skip == 33'd0) ? PH_CTAG : PH_SKIP;
                PH_CTAG:  n_phase = PH_CSIZE;
                PH_CSIZE: n_phase = (c_chunk_skip == 33'd0) ? PH_CTAG : PH_SKIP;
                default:  n_phase = PH_DONE;
            endcase
        end
    end

    // Field gathering and skip count.
    always_comb begin
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_skip  = r_skip;
        if (c_restart) begin
            n_cnt   = 2'd0;
            n_shift = 32'd0;
            n_skip  = 33'd0;
        end else if (c_byte && (r_phase == PH_SKIP)) begin
            n_skip = r_skip - 33'd1;
        end else if (c_field) begin
            if (c_done) begin
                n_cnt   = 2'd0;
                n_shift = 32'd0;
                if (r_phase == PH_BITS) begin
                    n_skip = c_fmt_skip;
                end else if (r_phase == PH_CSIZE) begin
                    n_skip = c_chunk_skip;
                end
            end else begin
                n_cnt   = c_cnt_nx[1:0];
                n_shift = c_v;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take && c_res) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_cnt       <= 2'd0;
            r_shift     <= 32'd0;
            r_skip      <= 33'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
    end

    // Held fmt fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || c_restart) begin
            r_fmt_len <= 32'd0;
            r_chan    <= 16'd0;
            r_rate    <= 32'd0;
            r_brate   <= 32'd0;
            r_align   <= 16'd0;
            r_bits    <= 6'd0;
            r_is_data <= 1'b0;
        end else if (c_field && c_done) begin
            unique case (r_phase)
                PH_FSIZE: r_fmt_len <= c_v;
                PH_CHAN:  r_chan    <= c_v[15:0];
                PH_RATE:  r_rate    <= c_v;
                PH_BRATE: r_brate   <= c_v;
                PH_ALIGN: r_align   <= c_v[15:0];
                PH_BITS:  r_bits    <= c_v[5:0];
                PH_CTAG:  r_is_data <= (c_v == TAG_DATA);
                default:  r_is_data <= r_is_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && c_res) begin
            r_status <= c_res_status;
            if (c_res_ok) begin
                r_o_chan   <= r_chan;
                r_o_rate   <= r_rate;
                r_o_bits   <= r_bits;
                r_o_bps    <= bytes_for(r_bits);
                r_o_signed <= (r_bits > 6'd8);
                r_o_size   <= c_v;
            end else begin
                r_o_chan   <= 16'd0;
                r_o_rate   <= 32'd0;
                r_o_bits   <= 6'd0;
                r_o_bps    <= 3'd0;
                r_o_signed <= 1'b0;
                r_o_size   <= 32'd0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_channels         = r_o_chan;
    assign o_sample_rate      = r_o_rate;
    assign o_bits_per_sample  = r_o_bits;
    assign o_bytes_per_sample = r_o_bps;
    assign o_signed_samples   = r_o_signed;
    assign o_data_size        = r_o_size;

endmodule

`default_nettype wire

// ===== sv/wavhp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_checker
    import wavhp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  o_status,
    input wire logic [15:0] o_channels,
    input wire logic [31:0] o_sample_rate,
    input wire logic [5:0]  o_bits_per_sample,
    input wire logic [2:0]  o_bytes_per_sample,
    input wire logic        o_signed_samples,
    input wire logic [31:0] o_data_size
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_data_size) && $stable(o_sample_rate))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_channels == 16'd0)
            && (o_sample_rate == 32'd0) && (o_data_size == 32'd0)
            && (o_bits_per_sample == 6'd0) && !o_signed_samples)
        else $error("error result carries format fields");

    a_ok_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK) |-> (o_channels != 16'd0)
            && ((o_bits_per_sample == 6'd8 && o_bytes_per_sample == 3'd1)
             || (o_bits_per_sample == 6'd16 && o_bytes_per_sample == 3'd2)
             || (o_bits_per_sample == 6'd24 && o_bytes_per_sample == 3'd4)
             || (o_bits_per_sample == 6'd32 && o_bytes_per_sample == 3'd4))
            && (o_signed_samples == (o_bits_per_sample != 6'd8)))
        else $error("accepted format is inconsistent");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_TRUNCATED))
        else $error("status code out of range");

endmodule

bind wav_header_parser_core wavhp_checker u_wavhp_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wavhp_pkg::*;

    // The package names three kinds; the fourth encoding must leave the parser untouched.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_DIR = 25;
    localparam int unsigned STD_RATES [6] = '{8000, 11025, 22050, 44100, 48000, 96000};

    // Clock, reset and every block input start at a known value before the first edge.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_kind = KIND_BYTE;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_status;
    logic [15:0] o_channels;
    logic [31:0] o_sample_rate;
    logic [5:0]  o_bits_per_sample;
    logic [2:0]  o_bytes_per_sample;
    logic        o_signed_samples;
    logic [31:0] o_data_size;

    wav_header_parser_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_byte_value       (i_byte_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_channels         (o_channels),
        .o_sample_rate      (o_sample_rate),
        .o_bits_per_sample  (o_bits_per_sample),
        .o_bytes_per_sample (o_bytes_per_sample),
        .o_signed_samples   (o_signed_samples),
        .o_data_size        (o_data_size)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // One reported audio format, or an error code with every other field zero.
    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [5:0]  bits_per_sample;
        logic [2:0]  bytes_per_sample;
        logic        signed_samples;
        logic [31:0] data_size;
    } t_wav_fmt;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
    } t_beat;

    // A directed row may carry a hand-written status; rows without one go to the parser model.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
        logic       typed;
        logic [3:0] st;
    } t_dir_row;

    t_wav_fmt fmt_expect_q[$];
    t_beat    file_q[$];
    int       fail_cnt = 0;
    int       beat_cnt = 0;
    int       cycle_cnt = 0;
    int       stall_cnt = 0;
    bit       no_gaps = 1'b0;

    // ------------------------------------------------------------------
    // Header parser model. It tracks the same phases as the block and is
    // stepped once per accepted input beat.
    // ------------------------------------------------------------------
    t_phase      prs_ph;
    logic [2:0]  prs_nb;
    logic [31:0] prs_acc;
    logic [32:0] prs_skip;
    logic [31:0] prs_flen;
    logic [31:0] prs_rate;
    logic [31:0] prs_brate;
    logic [15:0] prs_chan;
    logic [15:0] prs_align;
    logic [15:0] prs_bits;
    logic        prs_is_data;
    logic        prs_done;

    function automatic void clear_parser();
        prs_ph      = PH_RIFF;
        prs_nb      = '0;
        prs_acc     = '0;
        prs_skip    = '0;
        prs_flen    = '0;
        prs_rate    = '0;
        prs_brate   = '0;
        prs_chan    = '0;
        prs_align   = '0;
        prs_bits    = '0;
        prs_is_data = 1'b0;
        prs_done    = 1'b0;
    endfunction

    // A zero-length region goes straight to the next chunk header.
    function automatic void start_skip(input logic [32:0] n);
        prs_skip = n;
        prs_ph   = (n == 33'd0) ? PH_CTAG : PH_SKIP;
    endfunction

    // Steps the model by one beat; returns 1 when the beat completes a parse.
    function automatic bit parse_beat(input logic [1:0] k, input logic [7:0] v,
                                      output t_wav_fmt res);
        logic [31:0] word;
        logic [2:0]  need;
        logic [2:0]  bps;
        logic [3:0]  code;
        bit          give;
        res  = '0;
        word = '0;
        give = 1'b0;
        code = ST_OK;
        if (k == KIND_RESTART) begin
            clear_parser();
            return 1'b0;
        end
        if (k == KIND_UNUSED || prs_done)
            return 1'b0;
        if (k == KIND_EOF) begin
            give = 1'b1;
            code = ST_TRUNCATED;
        end else if (prs_ph == PH_SKIP) begin
            prs_skip = prs_skip - 33'd1;
            if (prs_skip == 33'd0)
                prs_ph = PH_CTAG;
        end else begin
            // Fields arrive least significant byte first.
            prs_acc = prs_acc | (32'(v) << (8 * prs_nb[1:0]));
            prs_nb  = prs_nb + 3'd1;
            need = (prs_ph == PH_CODE || prs_ph == PH_CHAN || prs_ph == PH_ALIGN ||
                    prs_ph == PH_BITS) ? 3'd2 : 3'd4;
            if (prs_nb == need) begin
                word    = prs_acc;
                prs_acc = '0;
                prs_nb  = '0;
                case (prs_ph)
                    PH_RIFF: begin
                        if (word != TAG_RIFF) begin
                            give = 1'b1;
                            code = ST_RIFF;
                        end else
                            prs_ph = PH_RSIZE;
                    end
                    PH_RSIZE: prs_ph = PH_WAVE;
                    PH_WAVE: begin
                        if (word != TAG_WAVE) begin
                            give = 1'b1;
                            code = ST_WAVE;
                        end else
                            prs_ph = PH_FMT;
                    end
                    PH_FMT: begin
                        if (word != TAG_FMT) begin
                            give = 1'b1;
                            code = ST_FMT_TAG;
                        end else
                            prs_ph = PH_FSIZE;
                    end
                    PH_FSIZE: begin
                        if (word < FMT_MIN_LEN) begin
                            give = 1'b1;
                            code = ST_FMT_SHORT;
                        end else begin
                            prs_flen = word;
                            prs_ph   = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        if (word != 32'(FMT_PCM)) begin
                            give = 1'b1;
                            code = ST_NOT_PCM;
                        end else
                            prs_ph = PH_CHAN;
                    end
                    PH_CHAN: begin
                        prs_chan = word[15:0];
                        prs_ph   = PH_RATE;
                    end
                    PH_RATE: begin
                        prs_rate = word;
                        prs_ph   = PH_BRATE;
                    end
                    PH_BRATE: begin
                        prs_brate = word;
                        prs_ph    = PH_ALIGN;
                    end
                    PH_ALIGN: begin
                        prs_align = word[15:0];
                        prs_ph    = PH_BITS;
                    end
                    PH_BITS: begin
                        // The fmt fields are judged here, before any of the fmt tail is
                        // skipped. Products are exact, so an overflowing byte rate fails.
                        prs_bits = word[15:0];
                        bps = (prs_bits == 16'd24) ? 3'd4 : 3'(prs_bits / 16'd8);
                        give = 1'b1;
                        if (prs_bits < 16'd8 || prs_bits > 16'd32 || prs_bits[2:0] != 3'd0)
                            code = ST_BITS;
                        else if (prs_chan == 16'd0)
                            code = ST_CHANNELS;
                        else if (64'(prs_align) != 64'(prs_chan) * 64'(bps))
                            code = ST_ALIGN;
                        else if (64'(prs_brate) != 64'(prs_rate) * 64'(prs_chan) * 64'(bps))
                            code = ST_RATE;
                        else begin
                            give = 1'b0;
                            start_skip(((33'(prs_flen) + 33'd1) & ~33'd1) -
                                       33'(FMT_MIN_LEN));
                        end
                    end
                    PH_CTAG: begin
                        prs_is_data = (word == TAG_DATA);
                        prs_ph      = PH_CSIZE;
                    end
                    PH_CSIZE: begin
                        if (prs_is_data)
                            give = 1'b1;
                        else
                            start_skip((33'(word) + 33'd1) & ~33'd1);
                    end
                    default: begin
                        prs_ph   = PH_DONE;
                        prs_done = 1'b1;
                    end
                endcase
            end
        end
        if (give) begin
            prs_done   = 1'b1;
            prs_ph     = PH_DONE;
            res.status = code;
            if (code == ST_OK) begin
                res.channels         = prs_chan;
                res.sample_rate      = prs_rate;
                res.bits_per_sample  = prs_bits[5:0];
                res.bytes_per_sample = (prs_bits == 16'd24) ? 3'd4 : 3'(prs_bits / 16'd8);
                res.signed_samples   = (prs_bits > 16'd8);
                res.data_size        = word;
            end
        end
        return give;
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps: most are zero or short, a few are long. While no_gaps is
    // set both sides run at full rate.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sends one input beat. Valid is raised at a falling edge and held with a steady
    // payload until a rising edge finds ready high; the model then steps once.
    // A typed status from the directed table replaces the model's expectation.
    task automatic send_beat(input logic [1:0] k, input logic [7:0] v,
                             input logic typed, input logic [3:0] typed_st);
        t_wav_fmt got;
        bit       has;
        int       g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_byte_value <= v;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        has = parse_beat(k, v, got);
        if (typed) begin
            got        = '0;
            got.status = typed_st;
            has        = 1'b1;
        end
        if (has)
            fmt_expect_q.push_back(got);
        beat_cnt++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // File builder. Files are mostly well formed with random content, so
    // that most of them reach the data chunk; the rest carry broken tags,
    // bad fmt fields, truncation, a restart midway, or plain noise.
    // ------------------------------------------------------------------
    function automatic void put_b(input logic [1:0] k, input logic [7:0] v);
        t_beat bt;
        bt.kind = k;
        bt.val  = v;
        file_q.push_back(bt);
    endfunction

    function automatic void put_word(input logic [31:0] w, input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            put_b(KIND_BYTE, w[8*i +: 8]);
    endfunction

    // Flavor 0 is random. Flavor 1 is a clean file with an odd fmt length and an
    // odd-sized chunk before the data. Flavor 2 runs into end of file inside the
    // skip of a chunk of the largest size. Flavor 3 has a bad channel count behind
    // a huge fmt length, which must be reported at once.
    function automatic void build_file(input int flavor);
        logic [31:0] riff_tag, wave_tag, fmt_tag, flen, rate, brate, tag, csize;
        logic [15:0] code, chan, align, bsz;
        int          bps, tail, n_extra, i, j, n, cut, r;
        bit          clean;
        clean    = (flavor != 0);
        riff_tag = TAG_RIFF;
        wave_tag = TAG_WAVE;
        fmt_tag  = TAG_FMT;
        file_q.delete();
        put_b(KIND_RESTART, 8'($urandom));

        // Noise: random beats, sometimes behind a good RIFF tag.
        if (!clean && $urandom_range(99) < 5) begin
            if ($urandom_range(1))
                put_word(TAG_RIFF, 4);
            n = $urandom_range(1, 40);
            for (i = 0; i < n; i++)
                put_b(($urandom_range(9) == 0) ? KIND_UNUSED : KIND_BYTE, 8'($urandom));
            if ($urandom_range(1))
                put_b(KIND_EOF, 8'($urandom));
            return;
        end

        if (!clean && $urandom_range(99) < 4)
            riff_tag ^= 32'd1 << $urandom_range(31);
        if (!clean && $urandom_range(99) < 4)
            wave_tag ^= 32'd1 << $urandom_range(31);
        if (!clean && $urandom_range(99) < 4)
            fmt_tag ^= 32'd1 << $urandom_range(31);

        r = $urandom_range(9);
        if (flavor == 1)
            flen = 32'd19;
        else if (flavor == 3)
            flen = 32'hFFFF_FFF1;
        else if (r == 0)
            flen = $urandom_range(15);
        else if (r < 3)
            flen = 16 + $urandom_range(24);
        else
            flen = FMT_MIN_LEN;

        code = (!clean && $urandom_range(99) < 4) ? 16'($urandom) : FMT_PCM;

        r = $urandom_range(19);
        if (flavor == 3)
            chan = 16'd0;
        else if (clean)
            chan = 16'd2;
        else if (r == 0)
            chan = 16'd0;
        else if (r == 1)
            chan = 16'hFFFF;
        else if (r == 2)
            chan = 16'($urandom);
        else
            chan = 16'($urandom_range(1, 8));

        r = $urandom_range(19);
        if (clean)
            bsz = 16'd24;
        else if (r == 0)
            bsz = 16'($urandom_range(40));
        else if (r == 1)
            bsz = 16'($urandom);
        else
            bsz = 16'(8 * $urandom_range(1, 4));
        bps = (bsz == 16'd24) ? 4 : bsz / 8;

        r = $urandom_range(19);
        if (clean)
            rate = 32'd44100;
        else if (r == 0)
            rate = 32'd0;
        else if (r == 1)
            rate = 32'hFFFF_FFFF;
        else if (r == 2)
            rate = $urandom;
        else
            rate = STD_RATES[$urandom_range(5)];

        align = (!clean && $urandom_range(9) == 0) ? 16'($urandom) : 16'(chan * bps);
        brate = (!clean && $urandom_range(9) == 0) ? $urandom :
                32'(64'(rate) * 64'(chan) * 64'(bps));

        put_word(riff_tag, 4);
        put_word($urandom, 4);
        put_word(wave_tag, 4);
        put_word(fmt_tag, 4);
        put_word(flen, 4);
        put_word(32'(code), 2);
        put_word(32'(chan), 2);
        put_word(rate, 4);
        put_word(brate, 4);
        put_word(32'(align), 2);
        put_word(32'(bsz), 2);

        if (flavor == 3) begin
            // The result is already out; these bytes are ignored.
            for (i = 0; i < 6; i++)
                put_b(KIND_BYTE, 8'($urandom));
            return;
        end

        // Padded fmt tail.
        if (flen >= FMT_MIN_LEN) begin
            tail = ((int'(flen) + 1) & ~1) - 16;
            for (i = 0; i < tail; i++)
                put_b(KIND_BYTE, 8'($urandom));
        end

        n_extra = (flavor == 1) ? 1 : $urandom_range(0, 2);
        for (i = 0; i < n_extra; i++) begin
            // Tags one bit away from the data tag are near misses.
            tag = ($urandom_range(9) < 3) ? (TAG_DATA ^ (32'd1 << $urandom_range(31)))
                                          : $urandom;
            csize = (flavor == 1) ? 32'd5 : $urandom_range(0, 12);
            put_word(tag, 4);
            put_word(csize, 4);
            for (j = 0; j < ((int'(csize) + 1) & ~1); j++)
                put_b(KIND_BYTE, 8'($urandom));
        end

        if (flavor == 2) begin
            put_word(32'h4B4E_554A, 4);
            put_word(32'hFFFF_FFFF, 4);
            n = $urandom_range(0, 20);
            for (i = 0; i < n; i++)
                put_b(KIND_BYTE, 8'($urandom));
            put_b(KIND_EOF, 8'($urandom));
            return;
        end

        r = $urandom_range(9);
        csize = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        put_word(TAG_DATA, 4);
        put_word(csize, 4);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
            put_b(KIND_BYTE, 8'($urandom));
        if ($urandom_range(3) == 0)
            put_b(KIND_EOF, 8'($urandom));

        // Cut the file short: with end of file, or left open for the next restart.
        r = $urandom_range(99);
        if (!clean && r < 17) begin
            cut = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > cut)
                void'(file_q.pop_back());
            if (r < 12)
                put_b(KIND_EOF, 8'($urandom));
        end
    endfunction

    // Plays the built file, with the unused kind sprinkled in now and then.
    task automatic send_file();
        int i;
        for (i = 0; i < file_q.size(); i++) begin
            if ($urandom_range(99) < 2)
                send_beat(KIND_UNUSED, 8'($urandom), 1'b0, ST_OK);
            send_beat(file_q[i].kind, file_q[i].val, 1'b0, ST_OK);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready changes at the falling edge with random stalls.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : out_side
        int g;
        if (stall_cnt > 0) begin
            i_out_ready <= 1'b0;
            stall_cnt   <= stall_cnt - 1;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                stall_cnt   <= g - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string fname, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, fname, want_v, got_v);
            fail_cnt++;
        end
    endfunction

    // Every accepted result beat is matched against the oldest pending format.
    always @(posedge i_clk) begin : result_check
        t_wav_fmt want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (fmt_expect_q.size() == 0) begin
                $display("%0t: result with none pending: expected nothing, got status %0d",
                         $time, o_status);
                fail_cnt++;
            end else begin
                want = fmt_expect_q.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("channels", 32'(want.channels), 32'(o_channels));
                check_field("sample_rate", want.sample_rate, o_sample_rate);
                check_field("bits_per_sample", 32'(want.bits_per_sample),
                            32'(o_bits_per_sample));
                check_field("bytes_per_sample", 32'(want.bytes_per_sample),
                            32'(o_bytes_per_sample));
                check_field("signed_samples", 32'(want.signed_samples),
                            32'(o_signed_samples));
                check_field("data_size", want.data_size, o_data_size);
            end
        end
    end

    // Watchdog: the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycle_cnt, fmt_expect_q.size());
            $display("** wav_header_parser_core: FAILED **");
            $finish;
        end
    end

    // Directed beats: end of file straight after reset, beats ignored after a
    // result, the unused kind, a bad RIFF tag, end of file after the RIFF size with
    // an unused beat ahead of the size, and an all-zero tag.
    t_dir_row dir_tab [N_DIR] = '{
        '{KIND_EOF,     8'h00, 1'b1, ST_TRUNCATED},
        '{KIND_BYTE,    8'hFF, 1'b0, ST_OK},
        '{KIND_EOF,     8'hA5, 1'b0, ST_OK},
        '{KIND_RESTART, 8'hFF, 1'b0, ST_OK},
        '{KIND_UNUSED,  8'h52, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h52, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h49, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h46, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h58, 1'b1, ST_RIFF},
        '{KIND_RESTART, 8'h00, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h52, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h49, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h46, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h46, 1'b0, ST_OK},
        '{KIND_UNUSED,  8'hFF, 1'b0, ST_OK},
        '{KIND_BYTE,    8'hFF, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h00, 1'b0, ST_OK},
        '{KIND_BYTE,    8'hFF, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h00, 1'b0, ST_OK},
        '{KIND_EOF,     8'h00, 1'b1, ST_TRUNCATED},
        '{KIND_RESTART, 8'h5A, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h00, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h00, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h00, 1'b0, ST_OK},
        '{KIND_BYTE,    8'h00, 1'b1, ST_RIFF}
    };

    initial begin : stimulus
        int i;
        int f;
        clear_parser();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++)
            send_beat(dir_tab[i].kind, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].st);

        for (f = 1; f <= 3; f++) begin
            build_file(f);
            send_file();
        end

        // Random files until enough beats have gone through.
        while (beat_cnt < 1500) begin
            no_gaps = ($urandom_range(9) == 0);
            build_file(0);
            send_file();
        end
        no_gaps = 1'b0;
        i_in_valid <= 1'b0;

        // The tail covers the longest output stall so that a stray extra result
        // is still seen.
        while (fmt_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("** wav_header_parser_core: PASSED **");
        else
            $display("** wav_header_parser_core: FAILED **");
        $finish;
    end

endmodule
